// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character map for the base64url stream decoder.
package b64d_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int ACC_W       = 18;
    localparam int SEXTET_W    = 6;
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] LOWER_OFS  = 8'h47;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] DIGIT_OFS  = 8'h04;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [5:0] SEXTET_DASH  = 6'h3E;
    localparam logic [5:0] SEXTET_UNDER = 6'h3F;

    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t           kind;
        logic [SEXTET_W-1:0] sextet;
    } sym_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic       error;
    } result_t;

    function automatic sym_t map_symbol(input logic [SYMBOL_W-1:0] c);
        sym_t r;
        logic [7:0] diff;
        r.kind   = SYM_BAD;
        r.sextet = '0;
        diff     = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            diff = c - CH_UPPER_A;
            r.kind = SYM_DATA;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            diff = c - LOWER_OFS;
            r.kind = SYM_DATA;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            diff = c + DIGIT_OFS;
            r.kind = SYM_DATA;
        end else if (c == CH_DASH) begin
            diff = {2'b00, SEXTET_DASH};
            r.kind = SYM_DATA;
        end else if (c == CH_UNDER) begin
            diff = {2'b00, SEXTET_UNDER};
            r.kind = SYM_DATA;
        end else if (c == CH_PAD) begin
            r.kind = SYM_PAD;
        end
        r.sextet = diff[SEXTET_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/base64url_stream_decoder_core.sv =====
// Top level of the base64url stream decoder: character decode and result queue.
//
//   Channel  Direction  Ports                                            Carries
//   s_       in         s_valid s_ready s_symbol s_final_char            one character
//   m_       out        m_valid m_ready m_data_byte m_byte_valid         one result
//                       m_end_of_message m_error
//
// A character is decoded in the cycle it is accepted; its results (up to three) enter an
// eight-entry result queue and leave it one per cycle while m_ready is high.
// s_ready is high whenever the queue has room for three results, so a character can be
// taken every cycle; a stalled result side fills the queue and then holds off new requests.
// The one-result-per-cycle output port sets the ceiling of one byte per cycle on average.
// Synchronous active-low reset clears the decode state and empties the queue.
module base64url_stream_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_final_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_message,
    output logic       m_error
);
    import b64d_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]       pos_reg, pos_next;
    logic             pad_reg, pad_next;
    logic             err_reg, err_next;

    result_t          res [MAX_RESULTS];
    logic [1:0]       res_count;

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    sym_t             sym;
    logic             set_err;
    logic [23:0]      word;
    logic             s_fire, m_fire;

    assign s_ready = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid && m_ready;

    assign m_data_byte      = fifo_reg[rd_ptr_reg].data_byte;
    assign m_byte_valid     = fifo_reg[rd_ptr_reg].byte_valid;
    assign m_end_of_message = fifo_reg[rd_ptr_reg].end_of_message;
    assign m_error          = fifo_reg[rd_ptr_reg].error;

    assign sym  = map_symbol(s_symbol);
    assign word = {acc_reg, sym.sextet};

    always_comb begin
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        set_err   = 1'b0;
        res_count = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        if (!err_reg) begin
            if (pad_reg) begin
                if (s_final_char) begin
                    res[0]    = '{acc_reg[11:4], 1'b1, 1'b1, 1'b0};
                    res_count = 2'd1;
                end else begin
                    set_err = 1'b1;
                end
            end else begin
                unique case (sym.kind)
                    SYM_DATA: begin
                        if (pos_reg == POS_FOURTH) begin
                            res[0]    = '{word[23:16], 1'b1, 1'b0, 1'b0};
                            res[1]    = '{word[15:8], 1'b1, 1'b0, 1'b0};
                            res[2]    = '{word[7:0], 1'b1, s_final_char, 1'b0};
                            res_count = 2'd3;
                            acc_next  = '0;
                            pos_next  = '0;
                        end else if (s_final_char) begin
                            set_err = 1'b1;
                        end else begin
                            acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], sym.sextet};
                            pos_next = pos_reg + 2'd1;
                        end
                    end
                    SYM_PAD: begin
                        if (pos_reg == POS_THIRD && !s_final_char) begin
                            pad_next = 1'b1;
                            pos_next = POS_FOURTH;
                        end else if (pos_reg == POS_FOURTH && s_final_char) begin
                            res[0]    = '{acc_reg[17:10], 1'b1, 1'b0, 1'b0};
                            res[1]    = '{acc_reg[9:2], 1'b1, 1'b1, 1'b0};
                            res_count = 2'd2;
                        end else begin
                            set_err = 1'b1;
                        end
                    end
                    default: set_err = 1'b1;
                endcase
            end
        end

        // A message already in error, or one failing now, ends in a single error result.
        if (err_reg || set_err) begin
            if (s_final_char) begin
                res[0]    = '{8'h00, 1'b0, 1'b1, 1'b1};
                res_count = 2'd1;
            end else begin
                err_next = 1'b1;
            end
        end

        if (s_final_char) begin
            acc_next = '0;
            pos_next = '0;
            pad_next = 1'b0;
            err_next = 1'b0;
        end

        if (!s_fire) begin
            res_count = 2'd0;
        end
        count_next = count_reg + CNT_W'(res_count) - CNT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            pos_reg    <= '0;
            pad_reg    <= 1'b0;
            err_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_fire) begin
                acc_reg    <= acc_next;
                pos_reg    <= pos_next;
                pad_reg    <= pad_next;
                err_reg    <= err_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_count);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < res_count) begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= res[i];
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_end_of_message && !m_byte_valid)
        else $error("error result without end of message or with a byte");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_final_char |=> pos_reg == '0 && !err_reg && !pad_reg)
        else $error("decode state not cleared after final character");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |=> count_reg <= CNT_W'(MAX_RESULTS))
        else $error("result queue count jumped from empty");

endmodule
